// ----- rtl/core/phd_pkg.sv -----
// ----------------------------------------------------------------------------
// phd_pkg
// Shared types and constants of the packet header deframer.
// ----------------------------------------------------------------------------
package phd_pkg;

  // Header layout, big-endian, in bytes
  localparam int unsigned HeaderBytes   = 15;
  localparam int unsigned DestEnd       = 4;
  localparam int unsigned SourceEnd     = 8;
  localparam int unsigned AckEnd        = 10;
  localparam int unsigned SequenceEnd   = 14;

  localparam int unsigned PosWidth      = 8;
  localparam int unsigned TdataOutWidth = 136;

  localparam logic [7:0] PayloadLimitReset = 8'd8;

  typedef enum logic [1:0] {
    KindBegin = 2'd0,
    KindAck   = 2'd1,
    KindEnd   = 2'd2,
    KindData  = 2'd3
  } packet_kind_e;

  typedef enum logic {
    ItemHeader  = 1'b0,
    ItemPayload = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e   item_kind;
    logic [31:0]  destination_addr;
    logic [31:0]  source_address;
    logic [15:0]  acknowledge_id;
    logic [31:0]  sequence_value;
    logic [7:0]   payload_count;
    packet_kind_e packet_kind;
    logic         length_error;
    logic [7:0]   payload_byte;
    logic         frame_last;
  } phd_result_t;

endpackage

// ----- rtl/core/packet_header_deframer.sv -----
// ----------------------------------------------------------------------------
// packet_header_deframer
// Splits a received byte stream into a header result and payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one raw frame byte per transfer. The first 15
//   bytes of a frame are the big-endian header (destination, source,
//   acknowledge id, sequence, payload length). No result is produced for the
//   first 14 header bytes; the length byte yields one header result
//   (tuser = 0) with the decoded packet kind and the length error flag. Each
//   following payload byte is forwarded as one result (tuser = 1). tlast
//   marks the final result of a frame, then the next byte starts a new frame.
//   A result is registered and appears in the cycle after its input transfer;
//   one byte is taken every cycle while the master side keeps up. A single result register
//   sits between the sides: a stalled receiver holds it and s_axis_tready
//   drops until the result is taken. cfg_we_i writes the payload limit; it
//   is to be written only while no frame is in progress. Reset returns the
//   block to the start of a header and sets the limit to 8.
// ----------------------------------------------------------------------------
module packet_header_deframer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] in_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] destination_addr, [63:32] source_address, [79:64] acknowledge_id,
  // [111:80] sequence_value, [119:112] payload_count, [121:120] packet_kind,
  // [122] length_error, [130:123] payload_byte, [135:131] zero
  output logic [phd_pkg::TdataOutWidth-1:0] m_axis_tdata,
  output logic         m_axis_tuser,   // [0] item_kind
  output logic         m_axis_tlast    // frame_last
);
  import phd_pkg::*;

  logic [7:0]  limit_q;
  logic        out_valid_q, out_valid_d;
  phd_result_t out_q, out_d;
  logic        step;
  logic        res_valid;
  phd_result_t res;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  phd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (s_axis_tdata),
    .limit_i     (limit_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (step && res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= PayloadLimitReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.item_kind;
  assign m_axis_tlast  = out_q.frame_last;
  assign m_axis_tdata  = {5'd0,
                          out_q.payload_byte,
                          out_q.length_error,
                          out_q.packet_kind,
                          out_q.payload_count,
                          out_q.sequence_value,
                          out_q.acknowledge_id,
                          out_q.source_address,
                          out_q.destination_addr};

`ifndef ASSERT_OFF
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ItemPayload) |-> m_axis_tdata[122:0] == '0)
    else $error("payload result carries header fields");

  a_header_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ItemHeader) |->
      m_axis_tdata[130:123] == 8'd0 &&
      m_axis_tlast == (m_axis_tdata[119:112] == 8'd0))
    else $error("header result fields inconsistent");

  a_load_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res_valid |=> m_axis_tvalid)
    else $error("result lost after accepted byte");
`endif

endmodule

// ----- rtl/core/phd_parser.sv -----
// ----------------------------------------------------------------------------
// phd_parser
// Frame state: header assembly, kind decode and payload byte counting.
// ----------------------------------------------------------------------------
module phd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          limit_i,
  output logic                res_valid_o,
  output phd_pkg::phd_result_t res_o
);
  import phd_pkg::*;

  logic                payload_q, payload_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [31:0]         dest_q, dest_d;
  logic [31:0]         source_q, source_d;
  logic [15:0]         ack_q, ack_d;
  logic [31:0]         seq_q, seq_d;
  logic [7:0]          len_q, len_d;

  logic                pay_last;
  logic                len_byte;
  packet_kind_e        kind;

  assign pay_last = ({1'b0, pos_q} + 9'd1) >= {1'b0, len_q};
  assign len_byte = (pos_q == PosWidth'(HeaderBytes - 1));

  always_comb begin
    if (byte_i != 8'd0) begin
      kind = KindData;
    end else if (seq_q == 32'd0) begin
      kind = KindBegin;
    end else if (seq_q == 32'hFFFF_FFFF) begin
      kind = KindEnd;
    end else begin
      kind = KindAck;
    end
  end

  always_comb begin
    payload_d   = payload_q;
    pos_d       = pos_q;
    dest_d      = dest_q;
    source_d    = source_q;
    ack_d       = ack_q;
    seq_d       = seq_q;
    len_d       = len_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (payload_q) begin
      res_valid_o        = 1'b1;
      res_o.item_kind    = ItemPayload;
      res_o.payload_byte = byte_i;
      res_o.frame_last   = pay_last;
      if (step_i) begin
        if (pay_last) begin
          payload_d = 1'b0;
          pos_d     = '0;
        end else begin
          pos_d = pos_q + PosWidth'(1);
        end
      end
    end else begin
      res_valid_o            = len_byte;
      res_o.item_kind        = ItemHeader;
      res_o.destination_addr = dest_q;
      res_o.source_address   = source_q;
      res_o.acknowledge_id   = ack_q;
      res_o.sequence_value   = seq_q;
      res_o.payload_count    = byte_i;
      res_o.packet_kind      = kind;
      res_o.length_error     = byte_i > limit_i;
      res_o.frame_last       = (byte_i == 8'd0);
      if (step_i) begin
        priority if (pos_q < PosWidth'(DestEnd)) begin
          dest_d = {dest_q[23:0], byte_i};
        end else if (pos_q < PosWidth'(SourceEnd)) begin
          source_d = {source_q[23:0], byte_i};
        end else if (pos_q < PosWidth'(AckEnd)) begin
          ack_d = {ack_q[7:0], byte_i};
        end else if (pos_q < PosWidth'(SequenceEnd)) begin
          seq_d = {seq_q[23:0], byte_i};
        end else begin
          len_d = byte_i;
        end
        if (len_byte) begin
          pos_d     = '0;
          payload_d = (byte_i != 8'd0);
        end else begin
          pos_d = pos_q + PosWidth'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_q <= 1'b0;
      pos_q     <= '0;
    end else begin
      payload_q <= payload_d;
      pos_q     <= pos_d;
    end
  end

  // Header fields are fully rewritten in every frame before they are read
  always_ff @(posedge clk_i) begin
    dest_q   <= dest_d;
    source_q <= source_d;
    ack_q    <= ack_d;
    seq_q    <= seq_d;
    len_q    <= len_d;
  end

`ifndef ASSERT_OFF
  a_hdr_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !payload_q |-> pos_q <= PosWidth'(HeaderBytes - 1))
    else $error("header byte position out of range");

  a_pay_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    payload_q |-> (pos_q < len_q))
    else $error("payload position past length");

  a_enter_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !payload_q && len_byte |=> payload_q == (len_q != 8'd0))
    else $error("payload phase entry does not match length");
`endif

endmodule
